### hw/rtl/msw_pkg.sv
// Shared constants and types for the multi-device stall watchdog.
`timescale 1ns / 1ps

package msw_pkg;

    localparam int DEVICES   = 16;
    localparam int IDX_W     = 4;
    localparam int TOTAL_W   = 5;
    localparam int COUNT_W   = 64;
    localparam int TIME_W    = 32;
    localparam int STALL_W   = 31;

    localparam logic [STALL_W-1:0] STALL_RESET = STALL_W'(60000);

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [STALL_W-1:0] stall_t;
    typedef logic [DEVICES-1:0] dev_mask_t;

    typedef struct packed {
        logic first_seen;
        logic count_wr;
        logic time_wr;
        logic hung_clr;
        logic hung_set;
        logic hung_now;
    } msw_upd_t;

endpackage

### hw/rtl/msw_eval.sv
// Per-sample decision logic: first sighting, progress, idle restart, stall detection.
`timescale 1ns / 1ps

module msw_eval (
    input  logic              in_range,
    input  logic              seen,
    input  logic              hung,
    input  msw_pkg::count_t   stored_count,
    input  msw_pkg::time_t    last_time,
    input  msw_pkg::count_t   count,
    input  msw_pkg::time_t    now,
    input  logic              active,
    input  msw_pkg::stall_t   stall_ticks,
    output msw_pkg::msw_upd_t upd
);
    import msw_pkg::*;

    time_t elapsed;

    assign elapsed = now - last_time;

    always_comb begin
        upd = '0;
        if (in_range) begin
            if (!seen) begin
                upd.first_seen = 1'b1;
                upd.count_wr   = 1'b1;
                upd.time_wr    = 1'b1;
            end else if (count != stored_count) begin
                upd.count_wr = 1'b1;
                upd.time_wr  = 1'b1;
                upd.hung_clr = 1'b1;
            end else if (!active) begin
                upd.time_wr = 1'b1;
            end else if (!hung && (elapsed >= {1'b0, stall_ticks})) begin
                upd.hung_set = 1'b1;
            end
            upd.hung_now = (hung && !upd.hung_clr) || upd.hung_set;
        end
    end

endmodule

### hw/rtl/multi_device_stall_watchdog_unit.sv
// Top level of the multi-device stall watchdog.
`timescale 1ns / 1ps

// Usage:
//   The s_ channel carries one progress sample per transaction: device index,
//   device total of the poll, progress count, current time and active flag.
//   The m_ channel returns exactly one result per sample, in order: the device
//   index, newly hung, hung now and first seen.
//   cfg_we/cfg_wdata load the stall threshold in ticks; write it while idle.
//   The sample is held in the input register after acceptance; then the
//   per-device table lookup, compare and update land in the result register,
//   which drives m_valid. Throughput is one transaction per cycle while
//   m_ready does not stall the result register; the table update of one
//   sample is visible to the next one with no bubble.
//   When m_ready is low the result register holds and the input register
//   takes one more transaction before s_ready drops.
//   Reset clears the seen and hung flags, the known device total and the
//   threshold (back to 60000). Stored counts and times are not cleared; they
//   are read only after a first sighting has written them.

module multi_device_stall_watchdog_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  msw_pkg::stall_t  cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  msw_pkg::idx_t    s_device_index,
    input  msw_pkg::total_t  s_device_total,
    input  msw_pkg::count_t  s_progress_count,
    input  msw_pkg::time_t   s_now_ticks,
    input  logic             s_active,
    output logic             m_valid,
    input  logic             m_ready,
    output msw_pkg::idx_t    m_out_device,
    output logic             m_newly_hung,
    output logic             m_hung_now,
    output logic             m_first_seen
);
    import msw_pkg::*;

    stall_t    stall_ticks_reg;
    logic      in_valid_reg,  in_valid_next;
    idx_t      idx_reg;
    total_t    total_reg;
    count_t    count_reg;
    time_t     now_reg;
    logic      active_reg;

    dev_mask_t seen_reg, seen_next;
    dev_mask_t hung_reg, hung_next;
    total_t    known_total_reg, known_total_next;
    count_t    last_count_mem [DEVICES];
    time_t     last_time_mem  [DEVICES];

    logic      out_valid_reg, out_valid_next;
    idx_t      out_device_reg;
    logic      newly_reg, hung_now_reg, first_reg;

    logic      advance, process, s_fire;
    logic      resize, in_range;
    total_t    lo_total;
    dev_mask_t keep_mask, seen_adj, hung_adj;
    msw_upd_t  upd;

    assign advance = !out_valid_reg || m_ready;
    assign process = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign resize   = (idx_reg == '0) && (total_reg != known_total_reg);
    assign lo_total = (total_reg < known_total_reg) ? total_reg : known_total_reg;
    assign in_range = ({1'b0, idx_reg} < total_reg) && (int'(idx_reg) < DEVICES);

    always_comb begin
        for (int i = 0; i < DEVICES; i++) begin
            keep_mask[i] = (i < int'(lo_total));
        end
        seen_adj         = resize ? (seen_reg & keep_mask) : seen_reg;
        hung_adj         = resize ? (hung_reg & keep_mask) : hung_reg;
        known_total_next = resize ? total_reg : known_total_reg;
    end

    msw_eval u_eval (
        .in_range     (in_range),
        .seen         (seen_adj[idx_reg]),
        .hung         (hung_adj[idx_reg]),
        .stored_count (last_count_mem[idx_reg]),
        .last_time    (last_time_mem[idx_reg]),
        .count        (count_reg),
        .now          (now_reg),
        .active       (active_reg),
        .stall_ticks  (stall_ticks_reg),
        .upd          (upd)
    );

    always_comb begin
        seen_next = seen_adj;
        hung_next = hung_adj;
        if (upd.first_seen) begin
            seen_next[idx_reg] = 1'b1;
        end
        if (upd.hung_clr) begin
            hung_next[idx_reg] = 1'b0;
        end
        if (upd.hung_set) begin
            hung_next[idx_reg] = 1'b1;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_ticks_reg <= STALL_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            seen_reg        <= '0;
            hung_reg        <= '0;
            known_total_reg <= '0;
        end else begin
            if (cfg_we) begin
                stall_ticks_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process) begin
                seen_reg        <= seen_next;
                hung_reg        <= hung_next;
                known_total_reg <= known_total_next;
            end
        end
    end

    // payload and per-device table
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            idx_reg    <= s_device_index;
            total_reg  <= s_device_total;
            count_reg  <= s_progress_count;
            now_reg    <= s_now_ticks;
            active_reg <= s_active;
        end
        if (process) begin
            if (upd.count_wr) begin
                last_count_mem[idx_reg] <= count_reg;
            end
            if (upd.time_wr) begin
                last_time_mem[idx_reg] <= now_reg;
            end
            out_device_reg <= idx_reg;
            newly_reg      <= upd.hung_set;
            hung_now_reg   <= upd.hung_now;
            first_reg      <= upd.first_seen;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_device = out_device_reg;
    assign m_newly_hung = newly_reg;
    assign m_hung_now   = hung_now_reg;
    assign m_first_seen = first_reg;

endmodule

### hw/rtl/msw_checker.sv
// Port-level assertions for the stall watchdog, bound to the top level.
`timescale 1ns / 1ps

module msw_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input msw_pkg::idx_t  m_out_device,
    input logic           m_newly_hung,
    input logic           m_hung_now,
    input logic           m_first_seen
);
    import msw_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_device)
            && $stable(m_newly_hung) && $stable(m_hung_now) && $stable(m_first_seen))
        else $error("stalled result changed");

    a_newly_is_hung: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_newly_hung |-> m_hung_now)
        else $error("newly hung device not reported as hung");

    a_first_not_hung: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_first_seen |-> !m_hung_now && !m_newly_hung)
        else $error("first sighting reported as hung");

endmodule

bind multi_device_stall_watchdog_unit msw_checker u_msw_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_device (m_out_device),
    .m_newly_hung (m_newly_hung),
    .m_hung_now   (m_hung_now),
    .m_first_seen (m_first_seen)
);

### bench/watchdog_sb_pkg.sv
// Scoreboard for the stall watchdog: per-device state prediction and result checks.
`timescale 1ns / 1ps

package watchdog_sb_pkg;

    import msw_pkg::*;

    typedef struct packed {
        idx_t   idx;
        total_t total;
        count_t count;
        time_t  now;
        logic   active;
    } sample_t;

    typedef struct packed {
        idx_t device;
        logic newly_hung;
        logic hung_now;
        logic first_seen;
    } verdict_t;

    class watchdog_scoreboard;
        stall_t      threshold;
        dev_mask_t   seen;
        dev_mask_t   hung;
        count_t      stored_count [DEVICES];
        time_t       last_time [DEVICES];
        total_t      known_total;
        verdict_t    verdict_q[$];
        int unsigned mismatches;
        int unsigned samples_taken;
        int unsigned results_checked;
        int unsigned hung_reports;

        function new();
            threshold       = STALL_RESET;
            seen            = '0;
            hung            = '0;
            known_total     = '0;
            mismatches      = 0;
            samples_taken   = 0;
            results_checked = 0;
            hung_reports    = 0;
        endfunction

        function void set_threshold(stall_t value);
            threshold = value;
        endfunction

        function int unsigned pending();
            return verdict_q.size();
        endfunction

        function void note_sample(sample_t s);
            verdict_t v;
            total_t   lo;
            time_t    elapsed;
            v.device     = s.idx;
            v.newly_hung = 1'b0;
            v.hung_now   = 1'b0;
            v.first_seen = 1'b0;
            samples_taken++;
            // forget devices at or above the smaller total on a resize
            if (s.idx == 0 && s.total != known_total) begin
                lo = (s.total < known_total) ? s.total : known_total;
                for (int i = 0; i < DEVICES; i++) begin
                    if (i >= lo) begin
                        seen[i] = 1'b0;
                        hung[i] = 1'b0;
                    end
                end
                known_total = s.total;
            end
            if (s.idx < s.total) begin
                elapsed = s.now - last_time[s.idx];
                if (!seen[s.idx]) begin
                    seen[s.idx]         = 1'b1;
                    stored_count[s.idx] = s.count;
                    last_time[s.idx]    = s.now;
                    v.first_seen        = 1'b1;
                end else if (s.count != stored_count[s.idx]) begin
                    stored_count[s.idx] = s.count;
                    last_time[s.idx]    = s.now;
                    hung[s.idx]         = 1'b0;
                end else if (!s.active) begin
                    last_time[s.idx] = s.now;
                end else if (!hung[s.idx] && elapsed >= TIME_W'(threshold)) begin
                    hung[s.idx]  = 1'b1;
                    v.newly_hung = 1'b1;
                end
                v.hung_now = hung[s.idx];
            end
            verdict_q.push_back(v);
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_verdict(verdict_t got);
            verdict_t want;
            results_checked++;
            if (verdict_q.size() == 0) begin
                report($sformatf("result for device %0d with no sample outstanding", got.device));
                return;
            end
            want = verdict_q.pop_front();
            if (got.device !== want.device)
                report($sformatf("out_device %0d, expected %0d", got.device, want.device));
            if (got.newly_hung !== want.newly_hung)
                report($sformatf("device %0d newly_hung %b, expected %b",
                                 want.device, got.newly_hung, want.newly_hung));
            if (got.hung_now !== want.hung_now)
                report($sformatf("device %0d hung_now %b, expected %b",
                                 want.device, got.hung_now, want.hung_now));
            if (got.first_seen !== want.first_seen)
                report($sformatf("device %0d first_seen %b, expected %b",
                                 want.device, got.first_seen, want.first_seen));
            if (want.newly_hung)
                hung_reports++;
        endtask
    endclass

endpackage

### bench/tb_top.sv
// Top-level testbench for the multi-device stall watchdog.
`timescale 1ns / 1ps

module tb_top;

    import msw_pkg::*;
    import watchdog_sb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    logic   aclk             = 1'b0;
    logic   aresetn          = 1'b0;
    logic   cfg_we           = 1'b0;
    stall_t cfg_wdata        = '0;
    logic   s_valid          = 1'b0;
    idx_t   s_device_index   = '0;
    total_t s_device_total   = '0;
    count_t s_progress_count = '0;
    time_t  s_now_ticks      = '0;
    logic   s_active         = 1'b0;
    logic   m_ready          = 1'b0;
    logic   s_ready;
    logic   m_valid;
    idx_t   m_out_device;
    logic   m_newly_hung;
    logic   m_hung_now;
    logic   m_first_seen;

    watchdog_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    bit          hold_request   = 1'b0;
    int unsigned cycles         = 0;
    int unsigned settings_used  = 1;
    count_t      dev_count [DEVICES];
    time_t       poll_now;
    total_t      poll_total;
    sample_t     taken_sample;
    verdict_t    taken_verdict;

    always #5 aclk = ~aclk;

    multi_device_stall_watchdog_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_device_index   (s_device_index),
        .s_device_total   (s_device_total),
        .s_progress_count (s_progress_count),
        .s_now_ticks      (s_now_ticks),
        .s_active         (s_active),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_device     (m_out_device),
        .m_newly_hung     (m_newly_hung),
        .m_hung_now       (m_hung_now),
        .m_first_seen     (m_first_seen)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                taken_verdict.device     = m_out_device;
                taken_verdict.newly_hung = m_newly_hung;
                taken_verdict.hung_now   = m_hung_now;
                taken_verdict.first_seen = m_first_seen;
                sb.check_verdict(taken_verdict);
            end
            if (s_valid && s_ready) begin
                taken_sample.idx    = s_device_index;
                taken_sample.total  = s_device_total;
                taken_sample.count  = s_progress_count;
                taken_sample.now    = s_now_ticks;
                taken_sample.active = s_active;
                sb.note_sample(taken_sample);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_sample(idx_t idx, total_t total, count_t cnt, time_t now, logic act);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_device_index   <= idx;
        s_device_total   <= total;
        s_progress_count <= cnt;
        s_now_ticks      <= now;
        s_active         <= act;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_threshold(stall_t value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_threshold(value);
        settings_used++;
    endtask

    task automatic run_polls(int unsigned n_items);
        int unsigned taken;
        int unsigned last;
        idx_t        idx;
        total_t      tot;
        time_t       step;
        time_t       th;
        taken = 0;
        while (taken < n_items) begin
            if ($urandom_range(99) < 12) begin
                idx = idx_t'($urandom);
                tot = total_t'($urandom_range(1, DEVICES));
                send_sample(idx, tot, {$urandom, $urandom}, $urandom, 1'($urandom));
                if (idx < tot)
                    taken++;
            end else begin
                if ($urandom_range(99) < 10)
                    poll_total = total_t'($urandom_range(1, DEVICES));
                last = poll_total;
                // cut the poll short now and then
                if ($urandom_range(99) < 8)
                    last = $urandom_range(1, poll_total);
                for (int i = 0; i < last; i++) begin
                    if ($urandom_range(99) < 25)
                        dev_count[i] = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                                : dev_count[i] + 64'd1;
                    send_sample(idx_t'(i), poll_total, dev_count[i], poll_now,
                                $urandom_range(99) < 80);
                    taken++;
                end
                th = TIME_W'(sb.threshold);
                case ($urandom_range(4))
                    0:       step = $urandom_range(3);
                    1:       step = th / 3;
                    2:       step = th - 1;
                    3:       step = th;
                    default: step = $urandom;
                endcase
                poll_now += step;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DEVICES; i++)
            dev_count[i] = {$urandom, $urandom};
        poll_now   = $urandom;
        poll_total = 8;
        send_idle_pct = 16;
        recv_idle_pct = 64;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_sample(0, 4, 64'd0, 32'd0, 1'b1);
        send_sample(1, 4, '1, 32'hFFFF_FFF0, 1'b1);
        send_sample(0, 4, 64'd0, 32'd59999, 1'b1);
        send_sample(0, 4, 64'd0, 32'd60000, 1'b1);
        send_sample(0, 4, 64'd0, 32'd90000, 1'b1);
        send_sample(0, 4, 64'd5, 32'd90001, 1'b1);
        send_sample(1, 4, '1, 32'd59984, 1'b1);
        send_sample(2, 4, 64'h5555_5555_5555_5555, 32'd100, 1'b1);
        send_sample(2, 4, 64'h5555_5555_5555_5555, 32'd200000, 1'b0);
        send_sample(2, 4, 64'h5555_5555_5555_5555, 32'd259999, 1'b1);
        send_sample(5, 4, 64'd0, 32'd0, 1'b1);
        send_sample(15, 16, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 1'b1);
        send_sample(0, 16, 64'd5, 32'd300000, 1'b1);
        send_sample(15, 16, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 1'b1);
        send_sample(0, 2, 64'd5, 32'd300001, 1'b1);
        send_sample(1, 2, '1, 32'd70000, 1'b1);
        send_sample(2, 2, 64'd0, 32'd0, 1'b1);
        send_sample(0, 0, 64'd5, 32'd0, 1'b1);
        send_sample(0, 31, 64'd7, 32'hFFFF_FFFF, 1'b1);
        send_sample(15, 31, 64'd9, 32'd1, 1'b1);
        write_threshold('0);
        send_sample(0, 31, 64'd7, 32'hFFFF_FFFF, 1'b0);
        send_sample(0, 31, 64'd7, 32'hFFFF_FFFF, 1'b1);
        send_sample(0, 16, 64'd7, 32'd0, 1'b1);
        write_threshold(31'h7FFF_FFFF);
        send_sample(15, 16, 64'd9, 32'h7FFF_FFFF, 1'b1);
        send_sample(15, 16, 64'd9, 32'h8000_0000, 1'b1);

        write_threshold(31'd1000);
        run_polls(75);
        hold_request = 1'b1;
        run_polls(75);

        write_threshold(31'd1);
        send_idle_pct = 64;
        recv_idle_pct = 16;
        run_polls(75);
        drain();
        run_polls(75);

        write_threshold(31'h7FFF_FFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_polls(75);
        hold_request = 1'b1;
        run_polls(75);

        drain();
        repeat (8) @(posedge aclk);
        $display("Checked %0d results for %0d samples across %0d threshold settings",
                 sb.results_checked, sb.samples_taken, settings_used);
        $display("with %0d hung reports, long output stalls and full-rate stretches; %0d mismatches",
                 sb.hung_reports, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
